[hw/rtl/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants of the SD SPI-mode host sequencer
// Holds request and result payload structs, phase codes and card constants.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned BlockBytes    = 512;
  localparam int unsigned ResponsePolls = 10;
  localparam int unsigned WakeBytes     = 10;
  localparam int unsigned IdleTries     = 10;

  // command codes
  localparam logic [1:0] CmdInit = 2'd0;
  localparam logic [1:0] CmdRead = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;
  localparam logic [1:0] CmdCard = 2'd3;

  // register indexes
  localparam logic [2:0] RegInitRetry  = 3'd0;
  localparam logic [2:0] RegTokenRetry = 3'd1;
  localparam logic [2:0] RegBusyRetry  = 3'd2;
  localparam logic [2:0] RegSlowDiv    = 3'd3;
  localparam logic [2:0] RegFastDiv    = 3'd4;

  // status codes
  localparam logic [3:0] StOk         = 4'd0;
  localparam logic [3:0] StNotReady   = 4'd1;
  localparam logic [3:0] StNoIdle     = 4'd2;
  localparam logic [3:0] StEcho       = 4'd3;
  localparam logic [3:0] StInitTmo    = 4'd4;
  localparam logic [3:0] StRejected   = 4'd5;
  localparam logic [3:0] StBadToken   = 4'd6;
  localparam logic [3:0] StWrRejected = 4'd7;
  localparam logic [3:0] StBusyTmo    = 4'd8;

  typedef enum logic [4:0] {
    PhIdle, PhWake, PhCmd0, PhCmd8, PhCmd55, PhCmd41, PhCmd58, PhCmd16,
    PhCmd17, PhCmd24, PhCmd8Tail, PhCmd58Tail, PhInitEnd, PhRdToken,
    PhRdData, PhRdCrc, PhWrGap, PhWrData, PhWrCrc, PhWrResp, PhWrBusy, PhFinal
  } phase_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] block_number;
    logic [7:0]  card_byte;
    logic [7:0]  host_write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       select_active;
    logic [7:0] spi_divider;
    logic [7:0] read_data;
    logic       read_valid;
    logic       want_write_byte;
    logic       done_res;
    logic [3:0] status;
    logic       high_capacity;
    logic       card_ready;
  } res_t;

  // request after classification by the front part
  typedef struct packed {
    logic start;
    req_t req;
  } cls_t;

endpackage

[hw/rtl/sdspi_front.sv]
// ----------------------------------------------------------------------------
// sdspi_front: request intake
// Takes requests and tags them as start or card byte into a two-entry queue.
// ----------------------------------------------------------------------------
module sdspi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdspi_pkg::req_t   in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output sdspi_pkg::cls_t   q_data_o
);

  sdspi_pkg::cls_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready  = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_ptr_q];
  assign push = in_valid & in_ready;
  assign pop  = q_valid_o & q_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].start <= (in_data_i.command != sdspi_pkg::CmdCard);
      mem_q[wr_ptr_q].req   <= in_data_i;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/sdspi_back.sv]
// ----------------------------------------------------------------------------
// sdspi_back: card sequencer
// Runs the init, read and write phases one request at a time into an output
// register that holds a result until it is taken.
// ----------------------------------------------------------------------------
module sdspi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [19:0]       cfg_data_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  sdspi_pkg::cls_t   q_data_i,
  output logic              out_valid,
  input  logic              out_ready,
  output sdspi_pkg::res_t   out_data_o
);

  sdspi_pkg::phase_e phase_q, phase_d;
  logic [9:0]  bc_q, bc_d;
  logic [19:0] rc_q, rc_d;
  logic [47:0] frame_q, frame_d;
  logic [31:0] reply_q, reply_d;
  logic        blk_q, blk_d, init_q, init_d;
  logic [3:0]  pend_q, pend_d;
  logic [19:0] init_lim_q, tok_lim_q, busy_lim_q;
  logic [7:0]  slow_q, fast_q;
  logic        ov_q;
  sdspi_pkg::res_t od_q;

  sdspi_pkg::res_t r;
  logic        emit_res;
  logic [31:0] addr;
  logic [7:0]  b;
  logic [31:0] rsh;

  assign q_ready_o = !ov_q || out_ready;
  assign out_valid  = ov_q;
  assign out_data_o = od_q;
  assign b   = q_data_i.req.card_byte;
  assign rsh = {reply_q[23:0], b};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_lim_q <= 20'd40000;
      tok_lim_q  <= 20'd100000;
      busy_lim_q <= 20'd500000;
      slow_q     <= 8'd59;
      fast_q     <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdspi_pkg::RegInitRetry:  init_lim_q <= cfg_data_i;
        sdspi_pkg::RegTokenRetry: tok_lim_q  <= cfg_data_i;
        sdspi_pkg::RegBusyRetry:  busy_lim_q <= cfg_data_i;
        sdspi_pkg::RegSlowDiv:    slow_q     <= cfg_data_i[7:0];
        sdspi_pkg::RegFastDiv:    fast_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    phase_d = phase_q; bc_d = bc_q; rc_d = rc_q; frame_d = frame_q;
    reply_d = reply_q; blk_d = blk_q; init_d = init_q; pend_d = pend_q;
    r = '0;
    emit_res = 1'b0;
    addr = '0;
    if (q_data_i.start) begin
      if (phase_q == sdspi_pkg::PhIdle) begin
        emit_res = 1'b1;
        if (q_data_i.req.command == sdspi_pkg::CmdInit) begin
          init_d = 1'b0; blk_d = 1'b0; phase_d = sdspi_pkg::PhWake; bc_d = 10'd1;
          r.send_byte = 8'hFF; r.send_valid = 1'b1;
        end else if (!init_q) begin
          phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1; r.status = sdspi_pkg::StNotReady;
        end else begin
          addr = blk_q ? q_data_i.req.block_number
                       : {q_data_i.req.block_number[22:0], 9'd0};
          phase_d = (q_data_i.req.command == sdspi_pkg::CmdRead) ? sdspi_pkg::PhCmd17
                                                                 : sdspi_pkg::PhCmd24;
          frame_d = {(q_data_i.req.command == sdspi_pkg::CmdRead) ? 8'h51 : 8'h58,
                     addr, 8'hFF};
          bc_d = '0; r.send_byte = 8'hFF; r.send_valid = 1'b1;
        end
      end
    end else if (phase_q != sdspi_pkg::PhIdle) begin
      emit_res = 1'b1;
      r.send_byte = 8'hFF; r.send_valid = 1'b1;
      unique case (phase_q)
        sdspi_pkg::PhCmd0, sdspi_pkg::PhCmd8, sdspi_pkg::PhCmd55, sdspi_pkg::PhCmd41,
        sdspi_pkg::PhCmd58, sdspi_pkg::PhCmd16, sdspi_pkg::PhCmd17,
        sdspi_pkg::PhCmd24: begin
          if (bc_q < 10'd6) begin
            bc_d = bc_q + 10'd1;
            unique case (bc_q[2:0])
              3'd0: r.send_byte = frame_q[47:40];
              3'd1: r.send_byte = frame_q[39:32];
              3'd2: r.send_byte = frame_q[31:24];
              3'd3: r.send_byte = frame_q[23:16];
              3'd4: r.send_byte = frame_q[15:8];
              default: r.send_byte = frame_q[7:0];
            endcase
          end else if (bc_q == 10'd6) begin
            bc_d = 10'd7;
          end else if (b[7] && (bc_q - 10'd6) < 10'(sdspi_pkg::ResponsePolls)) begin
            bc_d = bc_q + 10'd1;
          end else begin
            bc_d = '0;
            unique case (phase_q)
              sdspi_pkg::PhCmd0: begin
                if (b == 8'h01) begin
                  phase_d = sdspi_pkg::PhCmd8; frame_d = 48'h48_000001AA_87;
                end else if (rc_q + 20'd1 < 20'(sdspi_pkg::IdleTries)) begin
                  rc_d = rc_q + 20'd1; frame_d = 48'h40_00000000_95;
                end else begin
                  r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                  r.status = sdspi_pkg::StNoIdle;
                end
              end
              sdspi_pkg::PhCmd8: begin
                if (b == 8'h01) begin
                  phase_d = sdspi_pkg::PhCmd8Tail; reply_d = '0;
                end else begin
                  rc_d = '0;
                  if (init_lim_q == '0) begin
                    r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                    r.status = sdspi_pkg::StInitTmo;
                  end else begin
                    phase_d = sdspi_pkg::PhCmd55; frame_d = 48'h77_00000000_65;
                  end
                end
              end
              sdspi_pkg::PhCmd55: begin
                phase_d = sdspi_pkg::PhCmd41; frame_d = 48'h69_40000000_77;
              end
              sdspi_pkg::PhCmd41: begin
                rc_d = rc_q + 20'd1;
                if (b == 8'h00) begin
                  phase_d = sdspi_pkg::PhCmd58; frame_d = 48'h7A_00000000_FD;
                end else if (rc_q + 20'd1 < init_lim_q && rc_q != 20'hFFFFF) begin
                  phase_d = sdspi_pkg::PhCmd55; frame_d = 48'h77_00000000_65;
                end else begin
                  r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                  r.status = sdspi_pkg::StInitTmo;
                end
              end
              sdspi_pkg::PhCmd58: begin
                if (b == 8'h00) begin
                  phase_d = sdspi_pkg::PhCmd58Tail; reply_d = '0;
                end else if (!blk_q) begin
                  phase_d = sdspi_pkg::PhCmd16; frame_d = 48'h50_00000200_FF;
                end else begin
                  phase_d = sdspi_pkg::PhInitEnd;
                end
              end
              sdspi_pkg::PhCmd16: phase_d = sdspi_pkg::PhInitEnd;
              sdspi_pkg::PhCmd17: begin
                if (b != 8'h00) begin
                  r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                  r.status = sdspi_pkg::StRejected;
                end else if (tok_lim_q == '0) begin
                  r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                  r.status = sdspi_pkg::StBadToken;
                end else begin
                  phase_d = sdspi_pkg::PhRdToken; rc_d = 20'd1;
                end
              end
              default: begin
                if (b != 8'h00) begin
                  r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                  r.status = sdspi_pkg::StRejected;
                end else begin
                  phase_d = sdspi_pkg::PhWrGap;
                end
              end
            endcase
          end
        end
        sdspi_pkg::PhWake: begin
          if (bc_q < 10'(sdspi_pkg::WakeBytes)) begin
            bc_d = bc_q + 10'd1;
          end else begin
            rc_d = '0; bc_d = '0; phase_d = sdspi_pkg::PhCmd0;
            frame_d = 48'h40_00000000_95;
          end
        end
        sdspi_pkg::PhCmd8Tail, sdspi_pkg::PhCmd58Tail: begin
          reply_d = rsh;
          bc_d = bc_q + 10'd1;
          if (bc_q + 10'd1 >= 10'd4) begin
            bc_d = '0;
            if (phase_q == sdspi_pkg::PhCmd8Tail) begin
              if (rsh[15:0] != 16'h01AA) begin
                r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                r.status = sdspi_pkg::StEcho;
              end else begin
                rc_d = '0;
                if (init_lim_q == '0) begin
                  r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
                  r.status = sdspi_pkg::StInitTmo;
                end else begin
                  phase_d = sdspi_pkg::PhCmd55; frame_d = 48'h77_00000000_65;
                end
              end
            end else begin
              blk_d = rsh[30];
              if (!rsh[30]) begin
                phase_d = sdspi_pkg::PhCmd16; frame_d = 48'h50_00000200_FF;
              end else begin
                phase_d = sdspi_pkg::PhInitEnd;
              end
            end
          end
        end
        sdspi_pkg::PhInitEnd: begin
          r = '0; init_d = 1'b1; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
          r.status = sdspi_pkg::StOk;
        end
        sdspi_pkg::PhRdToken: begin
          if (b == 8'hFF && rc_q < tok_lim_q) begin
            rc_d = rc_q + 20'd1;
          end else if (b != 8'hFE) begin
            r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
            r.status = sdspi_pkg::StBadToken;
          end else begin
            phase_d = sdspi_pkg::PhRdData; bc_d = '0;
          end
        end
        sdspi_pkg::PhRdData: begin
          r.read_data = b; r.read_valid = 1'b1;
          bc_d = bc_q + 10'd1;
          if (bc_q == 10'(sdspi_pkg::BlockBytes - 1)) begin
            phase_d = sdspi_pkg::PhRdCrc; bc_d = '0;
          end
        end
        sdspi_pkg::PhRdCrc: begin
          bc_d = bc_q + 10'd1;
          if (bc_q != '0) begin
            pend_d = sdspi_pkg::StOk; phase_d = sdspi_pkg::PhFinal;
          end
        end
        sdspi_pkg::PhWrGap: begin
          phase_d = sdspi_pkg::PhWrData; bc_d = '0;
          r.send_byte = 8'hFE; r.want_write_byte = 1'b1;
        end
        sdspi_pkg::PhWrData: begin
          if (bc_q < 10'(sdspi_pkg::BlockBytes)) begin
            r.send_byte = q_data_i.req.host_write_byte;
            bc_d = bc_q + 10'd1;
            r.want_write_byte = (bc_q + 10'd1 < 10'(sdspi_pkg::BlockBytes));
          end else begin
            phase_d = sdspi_pkg::PhWrCrc; bc_d = '0;
          end
        end
        sdspi_pkg::PhWrCrc: begin
          bc_d = bc_q + 10'd1;
          if (bc_q != '0) phase_d = sdspi_pkg::PhWrResp;
        end
        sdspi_pkg::PhWrResp: begin
          if (b[4:0] != 5'h05) begin
            r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1;
            r.status = sdspi_pkg::StWrRejected;
          end else if (busy_lim_q == '0) begin
            pend_d = sdspi_pkg::StBusyTmo; phase_d = sdspi_pkg::PhFinal;
          end else begin
            phase_d = sdspi_pkg::PhWrBusy; rc_d = 20'd1;
          end
        end
        sdspi_pkg::PhWrBusy: begin
          if (b == 8'hFF) begin
            pend_d = sdspi_pkg::StOk; phase_d = sdspi_pkg::PhFinal;
          end else if (rc_q < busy_lim_q) begin
            rc_d = rc_q + 20'd1;
          end else begin
            pend_d = sdspi_pkg::StBusyTmo; phase_d = sdspi_pkg::PhFinal;
          end
        end
        default: begin
          r = '0; phase_d = sdspi_pkg::PhIdle; r.done_res = 1'b1; r.status = pend_q;
        end
      endcase
    end
    r.select_active = (phase_d != sdspi_pkg::PhIdle) && (phase_d != sdspi_pkg::PhWake) &&
                      (phase_d != sdspi_pkg::PhInitEnd) && (phase_d != sdspi_pkg::PhFinal);
    r.spi_divider   = init_d ? fast_q : slow_q;
    r.high_capacity = blk_d;
    r.card_ready    = init_d;
  end

  // state registers, advanced when a queued request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdspi_pkg::PhIdle;
      bc_q <= '0; rc_q <= '0; frame_q <= '0; reply_q <= '0;
      blk_q <= 1'b0; init_q <= 1'b0; pend_q <= '0; ov_q <= 1'b0;
    end else begin
      if (out_ready) ov_q <= 1'b0;
      if (q_valid_i && q_ready_o) begin
        phase_q <= phase_d; bc_q <= bc_d; rc_q <= rc_d; frame_q <= frame_d;
        reply_q <= reply_d; blk_q <= blk_d; init_q <= init_d; pend_q <= pend_d;
        if (emit_res) ov_q <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o && emit_res) od_q <= r;
  end

endmodule

[hw/rtl/sd_spi_mode_host_sequencer.sv]
// ----------------------------------------------------------------------------
// sd_spi_mode_host_sequencer: SD card SPI-mode host, byte level
// Front intake queue feeding the card phase sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries starts (init, read, write) and,
//   for each byte sent, the byte the card returned plus a write data byte.
//   out channel (out_valid/out_ready) carries at most one result per
//   request: next byte to send, chip select, divider, read data, status.
//   Starts while busy and card bytes while idle give no result.
//   Path: a request passes the intake queue, then the sequencer output
//   register. Throughput: one request per cycle unless out_ready stalls,
//   set by the phase update of the sequencer; the SPI byte exchange sets
//   the real pace.
//   Configuration: cfg_we_i with cfg_idx_i and cfg_data_i, while idle.
//   Reset clears the queue, returns to idle, card not ready, registers to
//   their defaults. A stalled receiver holds the result register and the
//   two-entry queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module sd_spi_mode_host_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [19:0]     cfg_data_i,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdspi_pkg::req_t in_data_i,
  output logic            out_valid,
  input  logic            out_ready,
  output sdspi_pkg::res_t out_data_o
);

  logic            q_valid, q_ready;
  sdspi_pkg::cls_t q_data;

  // intake
  sdspi_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  // sequencer
  sdspi_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid, .out_ready, .out_data_o
  );

endmodule

[hw/rtl/sdspi_checker.sv]
// ----------------------------------------------------------------------------
// sdspi_checker: port-level checks of the host sequencer
// Watches the top level ports and reports violations.
// ----------------------------------------------------------------------------
module sdspi_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid,
  input logic            out_ready,
  input sdspi_pkg::res_t out_data_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_o))
    else $error("result changed while stalled");

  // a finished result sends nothing
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.done_res |-> !out_data_o.send_valid && !out_data_o.select_active)
    else $error("done with send");

  // status only on finish
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data_o.done_res |-> out_data_o.status == sdspi_pkg::StOk)
    else $error("status without done");

  // read data only while selected
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.read_valid |-> out_data_o.select_active && out_data_o.send_valid)
    else $error("read data while deselected");

endmodule

bind sd_spi_mode_host_sequencer sdspi_checker u_checker (
  .clk_i, .rst_ni, .out_valid, .out_ready, .out_data_o
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: SD SPI-mode host sequencer
// Drives host starts and emulated card bytes through the request channel,
// predicts every result with an in-bench sequencer model and checks each one.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 600000;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sdspi_pkg::req_t in_data_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sdspi_pkg::res_t out_data_o;

  sd_spi_mode_host_sequencer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_o(out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run state
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned requests_done = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned noise_pct = 0;
  bit dead_card = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  sdspi_pkg::res_t pending_results[$];

  // sequencer model state
  sdspi_pkg::phase_e ph;
  int unsigned bcnt, rcnt;
  logic [47:0] frame;
  logic [31:0] reply_acc, card_addr;
  logic blk_addr, card_up;
  logic [3:0] held_status;
  int unsigned lim_init, lim_token, lim_busy;
  logic [7:0] div_slow, div_fast;
  sdspi_pkg::res_t nxt;

  function automatic void put_byte(logic [7:0] b);
    nxt.send_byte = b;
    nxt.send_valid = 1'b1;
  endfunction

  function automatic void end_op(logic [3:0] st);
    ph = sdspi_pkg::PhIdle;
    nxt.done_res = 1'b1;
    nxt.status = st;
  endfunction

  function automatic void open_cmd(sdspi_pkg::phase_e p, logic [5:0] idx, logic [31:0] arg,
                                   logic [7:0] crc);
    ph = p;
    frame = {2'b01, idx, arg, crc};
    bcnt = 0;
    put_byte(8'hFF);
  endfunction

  function automatic void go_tail(logic [3:0] st);
    held_status = st;
    ph = sdspi_pkg::PhFinal;
    put_byte(8'hFF);
  endfunction

  function automatic void begin_acmd41();
    rcnt = 0;
    if (lim_init == 0) end_op(sdspi_pkg::StInitTmo);
    else open_cmd(sdspi_pkg::PhCmd55, 6'd55, 32'h0, 8'h65);
  endfunction

  function automatic void after_ocr();
    if (!blk_addr) begin
      open_cmd(sdspi_pkg::PhCmd16, 6'd16, 32'd512, 8'hFF);
    end else begin
      ph = sdspi_pkg::PhInitEnd;
      put_byte(8'hFF);
    end
  endfunction

  // decision once a command reply byte is in
  function automatic void on_reply(logic [7:0] r1);
    case (ph)
      sdspi_pkg::PhCmd0: begin
        if (r1 == 8'h01) open_cmd(sdspi_pkg::PhCmd8, 6'd8, 32'h0000_01AA, 8'h87);
        else if (++rcnt < sdspi_pkg::IdleTries) open_cmd(sdspi_pkg::PhCmd0, 6'd0, 32'h0, 8'h95);
        else end_op(sdspi_pkg::StNoIdle);
      end
      sdspi_pkg::PhCmd8: begin
        if (r1 == 8'h01) begin
          ph = sdspi_pkg::PhCmd8Tail; bcnt = 0; reply_acc = 0; put_byte(8'hFF);
        end else begin
          begin_acmd41();
        end
      end
      sdspi_pkg::PhCmd55: open_cmd(sdspi_pkg::PhCmd41, 6'd41, 32'h4000_0000, 8'h77);
      sdspi_pkg::PhCmd41: begin
        rcnt++;
        if (r1 == 8'h00) open_cmd(sdspi_pkg::PhCmd58, 6'd58, 32'h0, 8'hFD);
        else if (rcnt < lim_init) open_cmd(sdspi_pkg::PhCmd55, 6'd55, 32'h0, 8'h65);
        else end_op(sdspi_pkg::StInitTmo);
      end
      sdspi_pkg::PhCmd58: begin
        if (r1 == 8'h00) begin
          ph = sdspi_pkg::PhCmd58Tail; bcnt = 0; reply_acc = 0; put_byte(8'hFF);
        end else begin
          after_ocr();
        end
      end
      sdspi_pkg::PhCmd16: begin
        ph = sdspi_pkg::PhInitEnd;
        put_byte(8'hFF);
      end
      sdspi_pkg::PhCmd17: begin
        if (r1 != 8'h00) end_op(sdspi_pkg::StRejected);
        else if (lim_token == 0) end_op(sdspi_pkg::StBadToken);
        else begin
          ph = sdspi_pkg::PhRdToken; rcnt = 1; put_byte(8'hFF);
        end
      end
      default: begin
        if (r1 != 8'h00) end_op(sdspi_pkg::StRejected);
        else begin
          ph = sdspi_pkg::PhWrGap; put_byte(8'hFF);
        end
      end
    endcase
  endfunction

  // card byte returned while an operation runs
  function automatic void on_card(logic [7:0] b, logic [7:0] host);
    if (ph >= sdspi_pkg::PhCmd0 && ph <= sdspi_pkg::PhCmd24) begin
      if (bcnt < 6) begin
        bcnt++;
        put_byte(frame[8*(6-bcnt) +: 8]);
      end else if (bcnt == 6) begin
        bcnt = 7; put_byte(8'hFF);
      end else if (b[7] && (bcnt - 6) < sdspi_pkg::ResponsePolls) begin
        bcnt++; put_byte(8'hFF);
      end else begin
        on_reply(b);
      end
      return;
    end
    case (ph)
      sdspi_pkg::PhWake: begin
        if (bcnt < sdspi_pkg::WakeBytes) begin
          bcnt++; put_byte(8'hFF);
        end else begin
          rcnt = 0; open_cmd(sdspi_pkg::PhCmd0, 6'd0, 32'h0, 8'h95);
        end
      end
      sdspi_pkg::PhCmd8Tail, sdspi_pkg::PhCmd58Tail: begin
        reply_acc = {reply_acc[23:0], b};
        if (++bcnt < 4) put_byte(8'hFF);
        else if (ph == sdspi_pkg::PhCmd8Tail) begin
          if (reply_acc[15:0] != 16'h01AA) end_op(sdspi_pkg::StEcho);
          else begin_acmd41();
        end else begin
          blk_addr = reply_acc[30];
          after_ocr();
        end
      end
      sdspi_pkg::PhInitEnd: begin
        card_up = 1'b1; end_op(sdspi_pkg::StOk);
      end
      sdspi_pkg::PhRdToken: begin
        if (b == 8'hFF && rcnt < lim_token) begin
          rcnt++; put_byte(8'hFF);
        end else if (b != 8'hFE) end_op(sdspi_pkg::StBadToken);
        else begin
          ph = sdspi_pkg::PhRdData; bcnt = 0; put_byte(8'hFF);
        end
      end
      sdspi_pkg::PhRdData: begin
        nxt.read_data = b;
        nxt.read_valid = 1'b1;
        if (++bcnt < sdspi_pkg::BlockBytes) put_byte(8'hFF);
        else begin
          ph = sdspi_pkg::PhRdCrc; bcnt = 0; put_byte(8'hFF);
        end
      end
      sdspi_pkg::PhRdCrc: begin
        if (++bcnt < 2) put_byte(8'hFF);
        else go_tail(sdspi_pkg::StOk);
      end
      sdspi_pkg::PhWrGap: begin
        ph = sdspi_pkg::PhWrData; bcnt = 0; put_byte(8'hFE); nxt.want_write_byte = 1'b1;
      end
      sdspi_pkg::PhWrData: begin
        if (bcnt < sdspi_pkg::BlockBytes) begin
          put_byte(host);
          if (++bcnt < sdspi_pkg::BlockBytes) nxt.want_write_byte = 1'b1;
        end else begin
          ph = sdspi_pkg::PhWrCrc; bcnt = 0; put_byte(8'hFF);
        end
      end
      sdspi_pkg::PhWrCrc: begin
        if (++bcnt < 2) put_byte(8'hFF);
        else begin
          ph = sdspi_pkg::PhWrResp; put_byte(8'hFF);
        end
      end
      sdspi_pkg::PhWrResp: begin
        if (b[4:0] != 5'h05) end_op(sdspi_pkg::StWrRejected);
        else if (lim_busy == 0) go_tail(sdspi_pkg::StBusyTmo);
        else begin
          ph = sdspi_pkg::PhWrBusy; rcnt = 1; put_byte(8'hFF);
        end
      end
      sdspi_pkg::PhWrBusy: begin
        if (b == 8'hFF) go_tail(sdspi_pkg::StOk);
        else if (rcnt < lim_busy) begin
          rcnt++; put_byte(8'hFF);
        end else go_tail(sdspi_pkg::StBusyTmo);
      end
      default: end_op(held_status);
    endcase
  endfunction

  // one request into the model; 1 when it yields a result in nxt
  function automatic bit sequence_step(sdspi_pkg::req_t q);
    nxt = '0;
    if (q.command == sdspi_pkg::CmdCard) begin
      if (ph == sdspi_pkg::PhIdle) return 1'b0;
      on_card(q.card_byte, q.host_write_byte);
    end else begin
      if (ph != sdspi_pkg::PhIdle) return 1'b0;
      if (q.command == sdspi_pkg::CmdInit) begin
        card_up = 1'b0; blk_addr = 1'b0;
        ph = sdspi_pkg::PhWake; bcnt = 1; put_byte(8'hFF);
      end else if (!card_up) begin
        end_op(sdspi_pkg::StNotReady);
      end else begin
        card_addr = blk_addr ? q.block_number : q.block_number * 32'd512;
        if (q.command == sdspi_pkg::CmdRead) begin
          open_cmd(sdspi_pkg::PhCmd17, 6'd17, card_addr, 8'hFF);
        end else begin
          open_cmd(sdspi_pkg::PhCmd24, 6'd24, card_addr, 8'hFF);
        end
      end
    end
    nxt.select_active = !(ph == sdspi_pkg::PhIdle || ph == sdspi_pkg::PhWake ||
                          ph == sdspi_pkg::PhInitEnd || ph == sdspi_pkg::PhFinal);
    nxt.spi_divider = card_up ? div_fast : div_slow;
    nxt.high_capacity = blk_addr;
    nxt.card_ready = card_up;
    return 1'b1;
  endfunction

  // emulated card: answer for the byte just exchanged
  function automatic logic [7:0] card_answer();
    logic [7:0] b;
    b = 8'($urandom);
    if (dead_card) return 8'hFF;
    if (ph >= sdspi_pkg::PhCmd0 && ph <= sdspi_pkg::PhCmd24) begin
      if (bcnt >= 6 && $urandom_range(3) != 0) begin
        case (ph)
          sdspi_pkg::PhCmd0:  b = 8'h01;
          sdspi_pkg::PhCmd8:  b = ($urandom_range(5) == 0) ? 8'h05 : 8'h01;
          sdspi_pkg::PhCmd55: b = 8'h01;
          sdspi_pkg::PhCmd41: b = $urandom_range(1) ? 8'h00 : 8'h01;
          default: b = 8'h00;
        endcase
      end else if (bcnt >= 6) begin
        b = 8'hFF;
      end
    end else begin
      case (ph)
        sdspi_pkg::PhCmd8Tail:  b = (bcnt == 2) ? 8'h01 : (bcnt == 3) ? 8'hAA : 8'h00;
        sdspi_pkg::PhCmd58Tail: if (bcnt == 0) b = $urandom_range(1) ? 8'hC0 : 8'h80;
        sdspi_pkg::PhRdToken:   b = $urandom_range(1) ? 8'hFE : 8'hFF;
        sdspi_pkg::PhWrResp:    b = {b[7:5], 5'h05};
        sdspi_pkg::PhWrBusy:    b = $urandom_range(1) ? 8'hFF : 8'h00;
        default: ;
      endcase
    end
    if ($urandom_range(99) < noise_pct) b = 8'($urandom);
    return b;
  endfunction

  // mismatch report
  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result checker
  always @(posedge clk_i) begin
    sdspi_pkg::res_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("send_byte", 32'(out_data_o.send_byte), 32'(want.send_byte));
        check_field("send_valid", 32'(out_data_o.send_valid), 32'(want.send_valid));
        check_field("select_active", 32'(out_data_o.select_active),
                    32'(want.select_active));
        check_field("spi_divider", 32'(out_data_o.spi_divider), 32'(want.spi_divider));
        check_field("read_data", 32'(out_data_o.read_data), 32'(want.read_data));
        check_field("read_valid", 32'(out_data_o.read_valid), 32'(want.read_valid));
        check_field("want_write_byte", 32'(out_data_o.want_write_byte),
                    32'(want.want_write_byte));
        check_field("done_res", 32'(out_data_o.done_res), 32'(want.done_res));
        check_field("status", 32'(out_data_o.status), 32'(want.status));
        check_field("high_capacity", 32'(out_data_o.high_capacity),
                    32'(want.high_capacity));
        check_field("card_ready", 32'(out_data_o.card_ready), 32'(want.card_ready));
      end
    end
  end

  // receiver stalls, with a long hold when asked
  always @(posedge clk_i) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // send one request and record what it should yield
  task automatic send_request(sdspi_pkg::req_t q);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (!in_ready);
    if (sequence_step(q)) begin
      pending_results.push_back(nxt);
      requests_done++;
    end
  endtask

  function automatic sdspi_pkg::req_t make_req(logic [1:0] cmd);
    sdspi_pkg::req_t q;
    q.command = cmd;
    q.block_number = $urandom;
    q.card_byte = 8'($urandom);
    q.host_write_byte = 8'($urandom);
    return q;
  endfunction

  // wait until every result has come back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      sdspi_pkg::RegInitRetry:  lim_init = 32'(val);
      sdspi_pkg::RegTokenRetry: lim_token = 32'(val);
      sdspi_pkg::RegBusyRetry:  lim_busy = 32'(val);
      sdspi_pkg::RegSlowDiv:    div_slow = val[7:0];
      sdspi_pkg::RegFastDiv:    div_fast = val[7:0];
      default: ;
    endcase
  endtask

  // full operation: start, then card bytes until it finishes
  task automatic run_op(logic [1:0] cmd, logic [31:0] blk);
    sdspi_pkg::req_t q;
    q = make_req(cmd);
    q.block_number = blk;
    send_request(q);
    while (ph != sdspi_pkg::PhIdle) begin
      if ($urandom_range(39) == 0) send_request(make_req(2'($urandom_range(2))));
      q = make_req(sdspi_pkg::CmdCard);
      q.card_byte = card_answer();
      send_request(q);
    end
  endtask

  // idle requests, starts before init, field extremes
  task automatic test_idle_requests();
    sdspi_pkg::req_t q;
    q = '0; q.command = sdspi_pkg::CmdCard;
    send_request(q);
    q = '1;
    send_request(q);
    run_op(sdspi_pkg::CmdRead, 32'h0);
    run_op(sdspi_pkg::CmdWrite, 32'hFFFF_FFFF);
    run_op(sdspi_pkg::CmdRead, 32'hFFFF_FFFF);
    run_op(sdspi_pkg::CmdWrite, 32'h0);
    settle();
  endtask

  // init limits at their extremes, including zero
  task automatic test_init_limits();
    write_reg(sdspi_pkg::RegInitRetry, 20'd0);
    run_op(sdspi_pkg::CmdInit, 32'h0);
    write_reg(sdspi_pkg::RegInitRetry, 20'd1);
    run_op(sdspi_pkg::CmdInit, 32'h0);
    settle();
    write_reg(sdspi_pkg::RegInitRetry, 20'hFFFFF);
    write_reg(sdspi_pkg::RegSlowDiv, 20'd0);
    write_reg(sdspi_pkg::RegFastDiv, 20'd255);
    while (!card_up) run_op(sdspi_pkg::CmdInit, 32'h0);
    settle();
  endtask

  // read token and write busy limits at their extremes
  task automatic test_data_limits();
    write_reg(sdspi_pkg::RegTokenRetry, 20'd0);
    write_reg(sdspi_pkg::RegBusyRetry, 20'd0);
    run_op(sdspi_pkg::CmdRead, $urandom);
    run_op(sdspi_pkg::CmdWrite, 32'hFFFF_FFFF);
    settle();
    write_reg(sdspi_pkg::RegTokenRetry, 20'd1);
    write_reg(sdspi_pkg::RegBusyRetry, 20'd1);
    write_reg(sdspi_pkg::RegSlowDiv, 20'd255);
    write_reg(sdspi_pkg::RegFastDiv, 20'd0);
    run_op(sdspi_pkg::CmdRead, 32'h0);
    run_op(sdspi_pkg::CmdWrite, $urandom);
    settle();
    write_reg(sdspi_pkg::RegTokenRetry, 20'hFFFFF);
    write_reg(sdspi_pkg::RegBusyRetry, 20'hFFFFF);
  endtask

  task automatic random_config();
    settle();
    write_reg(sdspi_pkg::RegInitRetry, 20'($urandom_range(1) ? $urandom_range(1, 6)
                                                           : $urandom_range(8, 20'hFFFFF)));
    write_reg(sdspi_pkg::RegTokenRetry, 20'($urandom_range(3) == 0 ? $urandom_range(0, 3)
                                                                 : $urandom));
    write_reg(sdspi_pkg::RegBusyRetry, 20'($urandom_range(3) == 0 ? $urandom_range(0, 3)
                                                                : $urandom));
    write_reg(sdspi_pkg::RegSlowDiv, 20'($urandom));
    write_reg(sdspi_pkg::RegFastDiv, 20'($urandom));
  endtask

  // random mix of operations under one idling profile
  task automatic test_random(int unsigned gap, int unsigned stall, int unsigned quota,
                             bit pressure);
    int unsigned first;
    int unsigned pick;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    first = requests_done;
    if (pressure) hold_asked++;
    while (requests_done - first < quota) begin
      pick = $urandom_range(99);
      noise_pct = ($urandom_range(3) == 0) ? 4 : 0;
      dead_card = 1'b0;
      if (pick < 8) random_config();
      else if (pick < 13) begin
        dead_card = 1'b1;
        run_op(sdspi_pkg::CmdInit, $urandom);
      end else if (pick < 50) run_op(sdspi_pkg::CmdInit, $urandom);
      else if (pick < 75) run_op(sdspi_pkg::CmdRead, $urandom);
      else run_op(sdspi_pkg::CmdWrite, $urandom);
    end
    dead_card = 1'b0;
    settle();
  endtask

  initial begin
    ph = sdspi_pkg::PhIdle; bcnt = 0; rcnt = 0; frame = '0; reply_acc = '0;
    card_addr = '0; blk_addr = 1'b0; card_up = 1'b0; held_status = sdspi_pkg::StOk;
    lim_init = 40000; lim_token = 100000; lim_busy = 500000;
    div_slow = 8'd59; div_fast = 8'd3;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_requests();
    test_init_limits();
    test_data_limits();
    test_random(10, 73, 170, 1'b0);
    test_random(73, 10, 170, 1'b0);
    test_random(0, 0, 170, 1'b1);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
